@@ hw/rtl/mcp_pkg.sv @@
// ============================================================================
// mcp_pkg: shared types, codes and helpers for the MESI cache tag controller
// Holds address layout constants, MESI codes, report codes, the controller
// state type, command/status bundles and the tree pseudo-LRU functions.
// ============================================================================
package mcp_pkg;

   localparam int ADDR_W         = 32;
   localparam int WAYS           = 8;
   localparam int WAY_W          = 3;
   localparam int PLRU_W         = WAYS - 1;
   localparam int MAX_RPT        = 5;
   localparam int RPT_IDX_W      = 3;
   localparam int DEF_SET_BITS   = 15;
   localparam int DEF_OFFSET_BITS = 6;

   // request actions
   typedef enum logic [2:0] {
      ACT_DREAD      = 3'd0,
      ACT_DWRITE     = 3'd1,
      ACT_IREAD      = 3'd2,
      ACT_SNP_INV    = 3'd3,
      ACT_SNP_READ   = 3'd4,
      ACT_SNP_WRITE  = 3'd5,
      ACT_SNP_RWIM   = 3'd6,
      ACT_CLEAR      = 3'd7
   } act_type;

   // MESI line states
   localparam logic [1:0] LS_I = 2'd0;
   localparam logic [1:0] LS_S = 2'd1;
   localparam logic [1:0] LS_E = 2'd2;
   localparam logic [1:0] LS_M = 2'd3;

   // bus answer from other caches
   localparam logic [1:0] BSN_NOHIT = 2'd0;

   // report kinds
   localparam logic [1:0] KIND_MSG = 2'd0;
   localparam logic [1:0] KIND_BUS = 2'd1;
   localparam logic [1:0] KIND_SNP = 2'd2;

   // upper-cache messages
   localparam logic [1:0] MSG_GET   = 2'd0;
   localparam logic [1:0] MSG_SEND  = 2'd1;
   localparam logic [1:0] MSG_INV   = 2'd2;
   localparam logic [1:0] MSG_EVICT = 2'd3;

   // bus operations
   localparam logic [1:0] BUS_READ  = 2'd0;
   localparam logic [1:0] BUS_WRITE = 2'd1;
   localparam logic [1:0] BUS_INV   = 2'd2;
   localparam logic [1:0] BUS_RWIM  = 2'd3;

   // own snoop replies
   localparam logic [1:0] SNP_NOHIT = 2'd0;
   localparam logic [1:0] SNP_HIT   = 2'd1;
   localparam logic [1:0] SNP_HITM  = 2'd2;

   typedef enum logic [2:0] {
      CS_INIT,
      CS_IDLE,
      CS_UPDATE,
      CS_EMIT,
      CS_CLEAR
   } ctl_state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        code;
      logic [ADDR_W-1:0] addr;
   } rpt_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request and read its set
      logic update;      // evaluate, write set back, load reports
      logic clear_step;  // write one cleared row
      logic clear_plru;  // also clear the pseudo-LRU row
      logic pop;         // one report transaction taken
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;    // sweep at its final row
      logic has_rpt;     // current evaluation yields reports
      logic rpt_last;    // report on output is the final one
   } sts_type;

   // Point tree bits away from way w (mark most recently used).
   function automatic logic [PLRU_W-1:0] plru_touch(input logic [PLRU_W-1:0] t,
                                                    input logic [WAY_W-1:0] w);
      logic [PLRU_W-1:0] r;
      r    = t;
      r[0] = w[2];
      if (!w[2]) begin
         r[1] = w[1];
         if (!w[1]) r[3] = w[0];
         else       r[4] = w[0];
      end else begin
         r[2] = w[1];
         if (!w[1]) r[5] = w[0];
         else       r[6] = w[0];
      end
      return r;
   endfunction

   // Follow the tree to the pseudo-LRU way.
   function automatic logic [WAY_W-1:0] plru_victim(input logic [PLRU_W-1:0] t);
      logic [WAY_W-1:0] v;
      if (!t[0]) begin
         if (!t[2]) v = t[6] ? 3'd6 : 3'd7;
         else       v = t[5] ? 3'd4 : 3'd5;
      end else begin
         if (!t[1]) v = t[4] ? 3'd2 : 3'd3;
         else       v = t[3] ? 3'd0 : 3'd1;
      end
      return v;
   endfunction

endpackage

@@ hw/rtl/mcp_req_if.sv @@
// ============================================================================
// mcp_req_if: request channel
// Valid/ready channel carrying one cache request transaction.
// ============================================================================
interface mcp_req_if
   import mcp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic [ADDR_W-1:0] address;
   logic [1:0]        bus_snoop;

   modport source (output valid, action, address, bus_snoop, input ready);
   modport sink   (input valid, action, address, bus_snoop, output ready);
endinterface

@@ hw/rtl/mcp_rsp_if.sv @@
// ============================================================================
// mcp_rsp_if: report channel
// Valid/ready channel carrying one report transaction.
// ============================================================================
interface mcp_rsp_if
   import mcp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        report_kind;
   logic [1:0]        report_code;
   logic [ADDR_W-1:0] report_address;
   logic              was_hit;
   logic              last;

   modport source (output valid, report_kind, report_code, report_address, was_hit, last,
                   input ready);
   modport sink   (input valid, report_kind, report_code, report_address, was_hit, last,
                   output ready);
endinterface

@@ hw/rtl/mesi_cache_controller_plru_core.sv @@
// ============================================================================
// mesi_cache_controller_plru_core: 8-way MESI tag controller with tree PLRU
// Top level joining the controller state machine and the datapath.
// ============================================================================
// After reset the block sweeps every set to clear tags, line states and
// pseudo-LRU bits, and accepts no request until done. On accept a request
// reads the set row and its tree bits from single-port memories; the next
// cycle compares all eight ways, writes the row back and latches the report
// list. Its reports then leave one per cycle while rsp is ready. A snoop
// write returns straight to idle with no update and no reports. A clear
// request repeats the sweep over the line memory, leaving pseudo-LRU bits intact.
module mesi_cache_controller_plru_core
   import mcp_pkg::*;
#(
   parameter int SET_BITS    = DEF_SET_BITS,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input logic       clock,
   input logic       reset,
   mcp_req_if.sink   req_port,
   mcp_rsp_if.source rsp_port
);

   cmd_type cmd;
   sts_type sts;

   mcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_port.valid),
      .req_action (req_port.action),
      .req_ready  (req_port.ready),
      .rsp_valid  (rsp_port.valid),
      .rsp_ready  (rsp_port.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mcp_datapath #(
      .SET_BITS    (SET_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_port.action),
      .req_address        (req_port.address),
      .req_bus_snoop      (req_port.bus_snoop),
      .rsp_report_kind    (rsp_port.report_kind),
      .rsp_report_code    (rsp_port.report_code),
      .rsp_report_address (rsp_port.report_address),
      .rsp_was_hit        (rsp_port.was_hit),
      .rsp_last           (rsp_port.last)
   );

endmodule

@@ hw/rtl/mcp_ctrl.sv @@
// ============================================================================
// mcp_ctrl: controller state machine
// Sequences init sweep, lookup/update, report emission and clear sweeps.
// ============================================================================
module mcp_ctrl
   import mcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_action,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic          req_acc;

   assign req_acc = req_valid && (state_ff == CS_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_INIT;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_INIT: begin
            if (sts.clr_last) state_in = CS_IDLE;
         end
         CS_IDLE: begin
            if (req_acc) begin
               if (req_action == ACT_CLEAR)          state_in = CS_CLEAR;
               else if (req_action == ACT_SNP_WRITE) state_in = CS_IDLE;
               else                                  state_in = CS_UPDATE;
            end
         end
         CS_UPDATE: begin
            state_in = sts.has_rpt ? CS_EMIT : CS_IDLE;
         end
         CS_EMIT: begin
            if (rsp_ready && sts.rpt_last) state_in = CS_IDLE;
         end
         CS_CLEAR: begin
            if (sts.clr_last) state_in = CS_IDLE;
         end
         default: state_in = CS_INIT;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = (state_ff == CS_IDLE);
      rsp_valid      = (state_ff == CS_EMIT);
      cmd.load       = req_acc;
      cmd.update     = (state_ff == CS_UPDATE);
      cmd.clear_step = (state_ff == CS_INIT) || (state_ff == CS_CLEAR);
      cmd.clear_plru = (state_ff == CS_INIT);
      cmd.pop        = (state_ff == CS_EMIT) && rsp_ready;
   end

endmodule

@@ hw/rtl/mcp_datapath.sv @@
// ============================================================================
// mcp_datapath: tag/state and pseudo-LRU memories with lookup logic
// One set row holds all ways; a request reads it, evaluates hit, fill and
// victim, writes it back and loads the report list.
// ============================================================================
module mcp_datapath
   import mcp_pkg::*;
#(
   parameter int SET_BITS    = DEF_SET_BITS,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [2:0]        req_action,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [1:0]        req_bus_snoop,
   output logic [1:0]        rsp_report_kind,
   output logic [1:0]        rsp_report_code,
   output logic [ADDR_W-1:0] rsp_report_address,
   output logic              rsp_was_hit,
   output logic              rsp_last
);

   localparam int SETS   = 1 << SET_BITS;
   localparam int TAG_RAW = ADDR_W - SET_BITS - OFFSET_BITS;
   localparam int TAG_W  = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int LINE_W = TAG_W + 2;
   localparam int ROW_W  = WAYS * LINE_W;

   // memories
   logic [ROW_W-1:0]  row_mem  [SETS];
   logic [PLRU_W-1:0] plru_mem [SETS];

   // request and read registers
   logic [2:0]            act_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [1:0]            snoop_ff;
   logic [ROW_W-1:0]      row_rd_ff;
   logic [PLRU_W-1:0]     plru_rd_ff;
   logic [SET_BITS-1:0]   clr_idx_ff;

   // report list
   rpt_type                rpt_ff [MAX_RPT];
   rpt_type                rpt_in [MAX_RPT];
   logic [RPT_IDX_W-1:0]   cnt_ff, cnt_in;
   logic [RPT_IDX_W-1:0]   idx_ff;
   logic                   hit_ff;

   logic [SET_BITS-1:0]   req_set, set_q;
   logic [TAG_W-1:0]      tag_q;
   logic [ADDR_W-1:0]     tag_sh;

   logic [TAG_W-1:0]      way_tag [WAYS];
   logic [1:0]            way_st  [WAYS];
   logic [WAYS-1:0]       hitv, invv;
   logic [WAY_W-1:0]      hitw, fillw, vw, fw;
   logic                  hit, any_inv;
   logic [ADDR_W-1:0]     va;
   logic [ROW_W-1:0]      row_new;
   logic [PLRU_W-1:0]     plru_new;

   assign req_set = req_address[OFFSET_BITS +: SET_BITS];
   assign set_q   = addr_ff[OFFSET_BITS +: SET_BITS];
   assign tag_sh  = addr_ff >> (SET_BITS + OFFSET_BITS);
   assign tag_q   = tag_sh[TAG_W-1:0];

   // way unpack and compare
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_st[w]  = row_rd_ff[w*LINE_W +: 2];
         way_tag[w] = row_rd_ff[w*LINE_W + 2 +: TAG_W];
         hitv[w]    = (way_st[w] != LS_I) && (way_tag[w] == tag_q);
         invv[w]    = (way_st[w] == LS_I);
      end
   end

   // lowest matching and lowest invalid way
   always_comb begin
      hitw  = '0;
      fillw = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hitv[w]) hitw  = WAY_W'(w);
         if (invv[w]) fillw = WAY_W'(w);
      end
   end

   assign hit     = |hitv;
   assign any_inv = |invv;
   assign vw      = plru_victim(plru_rd_ff);
   assign fw      = any_inv ? fillw : vw;
   assign va      = ADDR_W'((64'(way_tag[vw]) << (SET_BITS + OFFSET_BITS))
                            | (64'(set_q) << OFFSET_BITS));

   // evaluation: new row, new tree, report list
   always_comb begin
      logic [RPT_IDX_W-1:0] n;
      n        = '0;
      row_new  = row_rd_ff;
      plru_new = plru_rd_ff;
      for (int k = 0; k < MAX_RPT; k++) rpt_in[k] = '{KIND_MSG, MSG_GET, addr_ff};
      case (act_ff)
         ACT_DREAD, ACT_DWRITE, ACT_IREAD: begin
            if (hit) begin
               rpt_in[n] = '{KIND_MSG, MSG_SEND, addr_ff}; n = n + 1'b1;
               plru_new  = plru_touch(plru_rd_ff, hitw);
               if (act_ff == ACT_DWRITE &&
                   (way_st[hitw] == LS_S || way_st[hitw] == LS_E)) begin
                  rpt_in[n] = '{KIND_BUS, BUS_INV, addr_ff}; n = n + 1'b1;
                  row_new[hitw*LINE_W +: 2] = LS_M;
               end
            end else begin
               if (!any_inv) begin
                  if (way_st[vw] == LS_M) begin
                     rpt_in[n] = '{KIND_MSG, MSG_GET, va};   n = n + 1'b1;
                     rpt_in[n] = '{KIND_BUS, BUS_WRITE, va}; n = n + 1'b1;
                  end
                  rpt_in[n] = '{KIND_MSG, MSG_EVICT, va}; n = n + 1'b1;
               end
               rpt_in[n] = '{KIND_BUS, (act_ff == ACT_DWRITE) ? BUS_RWIM : BUS_READ,
                             addr_ff};
               n = n + 1'b1;
               rpt_in[n] = '{KIND_MSG, MSG_SEND, addr_ff}; n = n + 1'b1;
               plru_new  = plru_touch(plru_rd_ff, fw);
               row_new[fw*LINE_W + 2 +: TAG_W] = tag_q;
               if (act_ff == ACT_DWRITE)         row_new[fw*LINE_W +: 2] = LS_M;
               else if (snoop_ff == BSN_NOHIT)   row_new[fw*LINE_W +: 2] = LS_E;
               else                              row_new[fw*LINE_W +: 2] = LS_S;
            end
         end
         ACT_SNP_INV: begin
            if (hit) begin
               row_new[hitw*LINE_W +: 2] = LS_I;
               rpt_in[n] = '{KIND_MSG, MSG_INV, addr_ff}; n = n + 1'b1;
            end
         end
         ACT_SNP_READ, ACT_SNP_RWIM: begin
            if (!hit) begin
               rpt_in[n] = '{KIND_SNP, SNP_NOHIT, addr_ff}; n = n + 1'b1;
            end else begin
               if (way_st[hitw] == LS_M) begin
                  rpt_in[n] = '{KIND_SNP, SNP_HITM, addr_ff}; n = n + 1'b1;
                  rpt_in[n] = '{KIND_MSG, MSG_GET, addr_ff};  n = n + 1'b1;
                  rpt_in[n] = '{KIND_BUS, BUS_WRITE, addr_ff}; n = n + 1'b1;
               end else begin
                  rpt_in[n] = '{KIND_SNP, SNP_HIT, addr_ff}; n = n + 1'b1;
               end
               if (act_ff == ACT_SNP_RWIM) begin
                  row_new[hitw*LINE_W +: 2] = LS_I;
                  rpt_in[n] = '{KIND_MSG, MSG_INV, addr_ff}; n = n + 1'b1;
               end else begin
                  row_new[hitw*LINE_W +: 2] = LS_S;
               end
            end
         end
         default: ;
      endcase
      cnt_in = n;
   end

   // memory write and read ports
   always_ff @(posedge clock) begin
      if (cmd.clear_step)  row_mem[clr_idx_ff] <= '0;
      else if (cmd.update) row_mem[set_q]      <= row_new;
      if (cmd.clear_step && cmd.clear_plru) plru_mem[clr_idx_ff] <= '0;
      else if (cmd.update)                  plru_mem[set_q]      <= plru_new;
      if (cmd.load) begin
         row_rd_ff  <= row_mem[req_set];
         plru_rd_ff <= plru_mem[req_set];
      end
   end

   // request capture and report list
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         addr_ff  <= req_address;
         snoop_ff <= req_bus_snoop;
      end
      if (cmd.update) begin
         for (int k = 0; k < MAX_RPT; k++) rpt_ff[k] <= rpt_in[k];
         hit_ff <= hit;
      end
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         cnt_ff     <= '0;
         idx_ff     <= '0;
      end else begin
         if (cmd.clear_step) clr_idx_ff <= clr_idx_ff + 1'b1;
         if (cmd.update) begin
            cnt_ff <= cnt_in;
            idx_ff <= '0;
         end else if (cmd.pop) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   assign sts.clr_last = &clr_idx_ff;
   assign sts.has_rpt  = (cnt_in != '0);
   assign sts.rpt_last = (idx_ff == cnt_ff - 1'b1);

   assign rsp_report_kind    = rpt_ff[idx_ff].kind;
   assign rsp_report_code    = rpt_ff[idx_ff].code;
   assign rsp_report_address = rpt_ff[idx_ff].addr;
   assign rsp_was_hit        = hit_ff;
   assign rsp_last           = sts.rpt_last;

endmodule
